>>> rtl/signed_integer_divider_top_defines.svh
// assertion macros for the signed integer divider
// used by the rtl files that carry concurrent assertions; no other dependencies
`ifndef SIGNED_INTEGER_DIVIDER_TOP_DEFINES_SVH
`define SIGNED_INTEGER_DIVIDER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SID_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sid_pkg.sv
// shared constants and types for the signed integer divider
// no dependencies
package sid_pkg;

   localparam int DATA_WIDTH = 32;

   typedef struct packed {
      logic negate;
      logic div_zero;
   } sid_ctrl_type;

endpackage

>>> rtl/sid_cell.sv
// one restoring division cell: shift in a dividend bit, compare, subtract, record a quotient bit
// depends on sid_pkg and signed_integer_divider_top_defines.svh
`include "signed_integer_divider_top_defines.svh"

module sid_cell #(
   parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [DATA_WIDTH-1:0]  in_rem,
   input  logic [DATA_WIDTH-1:0]  in_num,
   input  logic [DATA_WIDTH-1:0]  in_den,
   input  logic [DATA_WIDTH-1:0]  in_quo,
   input  sid_pkg::sid_ctrl_type  in_ctrl,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [DATA_WIDTH-1:0]  out_rem,
   output logic [DATA_WIDTH-1:0]  out_num,
   output logic [DATA_WIDTH-1:0]  out_den,
   output logic [DATA_WIDTH-1:0]  out_quo,
   output sid_pkg::sid_ctrl_type  out_ctrl
);

   logic                  valid_ff, valid_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   sid_pkg::sid_ctrl_type ctrl_ff;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;
   logic                  load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      shifted  = {in_rem[DATA_WIDTH-2:0], in_num[DATA_WIDTH-1]};
      diff     = {1'b0, shifted} - {1'b0, in_den};
      fits     = !diff[DATA_WIDTH];
      rem_in   = fits ? diff[DATA_WIDTH-1:0] : shifted;
      num_in   = {in_num[DATA_WIDTH-2:0], 1'b0};
      quo_in   = {in_quo[DATA_WIDTH-2:0], fits};
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
         ctrl_ff <= in_ctrl;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_ctrl  = ctrl_ff;

   `SID_ASSERT_NOW(a_rem_below_den, clock, reset, valid_ff && (den_ff != '0), rem_ff < den_ff, "partial remainder not below divisor")
   `SID_ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff && !out_ready, valid_ff && $stable(quo_ff) && $stable(rem_ff), "stalled cell lost its transaction")
   `SID_ASSERT_NEXT(a_load_fills, clock, reset, in_valid && in_ready, valid_ff, "accepted transaction not held by cell")

endmodule

>>> rtl/signed_integer_divider_top.sv
// signed integer divider: operand prep stage, a chain of restoring division cells, output stage
// usage:
//   req channel carries one transaction of dividend and divisor (valid/ready)
//   rsp channel returns quotient truncated toward zero and a divide-by-zero flag
//   zero divisor gives quotient -1 with the flag set; most negative over -1
//   saturates to the largest positive value
//   rsp_valid rises once the transaction has passed the registers in order: the
//   operand magnitudes register at the accepting edge, then each quotient bit
//   registers in its own cell of the chain, then the sign fix-up registers in
//   the output stage
//   throughput is one transaction per cycle while rsp_ready stays high, since
//   every cell handles its own transaction each cycle
//   each stage has its own valid bit and fills empty slots, so when the
//   receiver stalls, new transactions keep entering until the chain is full,
//   then req_ready drops; nothing is lost or repeated
//   reset empties all stages at once; req_ready is high in the cycle after
//   reset is released
// depends on sid_pkg and sid_cell
module signed_integer_divider_top #(
   parameter int DATA_WIDTH = sid_pkg::DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [DATA_WIDTH-1:0]  req_dividend,
   input  logic signed [DATA_WIDTH-1:0]  req_divisor,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DATA_WIDTH-1:0]  rsp_quotient,
   output logic                          rsp_divide_by_zero
);

   localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] ONE      = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

   // operand prep stage
   logic                  prep_valid_ff, prep_valid_in;
   logic [DATA_WIDTH-1:0] prep_num_ff, prep_num_in;
   logic [DATA_WIDTH-1:0] prep_den_ff, prep_den_in;
   sid_pkg::sid_ctrl_type prep_ctrl_ff, prep_ctrl_in;
   logic                  prep_load;
   logic [DATA_WIDTH-1:0] a_bits, b_bits;
   logic                  b_zero;

   // cell chain links
   logic                  link_valid [0:DATA_WIDTH];
   logic                  link_ready [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] link_rem   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] link_num   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] link_den   [0:DATA_WIDTH];
   logic [DATA_WIDTH-1:0] link_quo   [0:DATA_WIDTH];
   sid_pkg::sid_ctrl_type link_ctrl  [0:DATA_WIDTH];

   // output stage
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_quo_ff, out_quo_in;
   logic                  out_dz_ff;
   logic                  out_load;

   assign req_ready = !prep_valid_ff || link_ready[0];
   assign prep_load = req_valid && req_ready;

   always_comb begin
      a_bits = req_dividend;
      b_bits = req_divisor;
      b_zero = (b_bits == '0);
      if ((a_bits == MOST_NEG) && (&b_bits)) begin
         prep_num_in = MOST_POS;
         prep_den_in = ONE;
         prep_ctrl_in.negate = 1'b0;
      end else begin
         prep_num_in = a_bits[DATA_WIDTH-1] ? (~a_bits + ONE) : a_bits;
         prep_den_in = b_bits[DATA_WIDTH-1] ? (~b_bits + ONE) : b_bits;
         prep_ctrl_in.negate = (a_bits[DATA_WIDTH-1] ^ b_bits[DATA_WIDTH-1]) && !b_zero;
      end
      prep_ctrl_in.div_zero = b_zero;
      prep_valid_in = prep_load ? 1'b1 : (link_ready[0] ? 1'b0 : prep_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= prep_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_load) begin
         prep_num_ff  <= prep_num_in;
         prep_den_ff  <= prep_den_in;
         prep_ctrl_ff <= prep_ctrl_in;
      end
   end

   assign link_valid[0] = prep_valid_ff;
   assign link_rem[0]   = '0;
   assign link_num[0]   = prep_num_ff;
   assign link_den[0]   = prep_den_ff;
   assign link_quo[0]   = '0;
   assign link_ctrl[0]  = prep_ctrl_ff;

   for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
      sid_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_rem    (link_rem[i]),
         .in_num    (link_num[i]),
         .in_den    (link_den[i]),
         .in_quo    (link_quo[i]),
         .in_ctrl   (link_ctrl[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_rem   (link_rem[i+1]),
         .out_num   (link_num[i+1]),
         .out_den   (link_den[i+1]),
         .out_quo   (link_quo[i+1]),
         .out_ctrl  (link_ctrl[i+1])
      );
   end

   // sign fix-up
   assign link_ready[DATA_WIDTH] = !out_valid_ff || rsp_ready;
   assign out_load = link_valid[DATA_WIDTH] && link_ready[DATA_WIDTH];

   always_comb begin
      out_quo_in = link_ctrl[DATA_WIDTH].negate ? (~link_quo[DATA_WIDTH] + ONE)
                                                : link_quo[DATA_WIDTH];
      out_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_quo_ff <= out_quo_in;
         out_dz_ff  <= link_ctrl[DATA_WIDTH].div_zero;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_quotient       = out_quo_ff;
   assign rsp_divide_by_zero = out_dz_ff;

endmodule

>>> tb/tb.sv
// testbench for signed_integer_divider_top: directed corner divisions, then random operands
// under four idle/stall mixes, each result checked against a local quotient predictor
// depends on sid_pkg and the divider rtl
`timescale 1ns / 100ps

module tb;

   localparam int W = sid_pkg::DATA_WIDTH;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = ~MOST_NEG;
   localparam logic [W-1:0] MINUS_ONE = '1;
   localparam int RANDOM_PER_PHASE = 432;
   localparam int SETTLE_CYCLES = W + 8;
   localparam int MAX_REPORTS = 30;

   typedef struct packed {
      logic [W-1:0] quotient;
      logic         divide_by_zero;
   } quotient_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [W-1:0]  req_dividend = '0;
   logic signed [W-1:0]  req_divisor = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [W-1:0]  rsp_quotient;
   logic                 rsp_divide_by_zero;

   quotient_type pending_quotients[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int divisions_sent = 0;
   int quotients_checked = 0;
   int zero_divisors = 0;
   int failures = 0;

   signed_integer_divider_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_quotient       (rsp_quotient),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic quotient_type divide_truncated(logic [W-1:0] a, logic [W-1:0] b);
      quotient_type r;
      logic [W-1:0] mag_a;
      logic [W-1:0] mag_b;
      logic [W-1:0] mag_q;
      logic [W:0]   partial;
      r.divide_by_zero = 1'b0;
      if (b == '0) begin
         r.quotient = MINUS_ONE;
         r.divide_by_zero = 1'b1;
      end else if (a == MOST_NEG && b == MOST_NEG) begin
         r.quotient = 1;
      end else if (b == MOST_NEG) begin
         r.quotient = '0;
      end else if (a == MOST_NEG && b == MINUS_ONE) begin
         r.quotient = MOST_POS;
      end else begin
         mag_a = a[W-1] ? -a : a;
         mag_b = b[W-1] ? -b : b;
         partial = '0;
         mag_q = '0;
         for (int i = W - 1; i >= 0; i--) begin
            partial = {partial[W-1:0], mag_a[i]};
            if (partial >= {1'b0, mag_b}) begin
               partial = partial - {1'b0, mag_b};
               mag_q[i] = 1'b1;
            end
         end
         r.quotient = (a[W-1] ^ b[W-1]) ? -mag_q : mag_q;
      end
      return r;
   endfunction

   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5:       v = $urandom >> $urandom_range(W - 1);
         6:          v = -($urandom >> $urandom_range(W - 1));
         7:          v = $urandom_range(32) - 16;
         8: begin
            case ($urandom_range(4))
               0:       v = MOST_NEG;
               1:       v = MOST_POS;
               2:       v = MINUS_ONE;
               3:       v = 1;
               default: v = '0;
            endcase
         end
         default:    v = '0;
      endcase
      return v;
   endfunction

   // check each returned transaction against the oldest prediction
   always @(posedge clock) begin : check_results
      quotient_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_quotients.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $error("unexpected result transaction: quotient %0d", rsp_quotient);
         end else begin
            want = pending_quotients.pop_front();
            quotients_checked++;
            if (rsp_quotient !== want.quotient) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("quotient: expected %0d, actual %0d",
                         $signed(want.quotient), rsp_quotient);
            end
            if (rsp_divide_by_zero !== want.divide_by_zero) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $error("divide_by_zero: expected %0b, actual %0b",
                         want.divide_by_zero, rsp_divide_by_zero);
            end
         end
      end
   end

   task automatic send_division(logic [W-1:0] dividend, logic [W-1:0] divisor);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dividend <= dividend;
      req_divisor <= divisor;
      do @(posedge clock); while (!req_ready);
      pending_quotients.push_back(divide_truncated(dividend, divisor));
      divisions_sent++;
      if (divisor == '0)
         zero_divisors++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_quotients.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_corner_cases();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      send_division('0, 1);
      send_division(1, 1);
      send_division(MINUS_ONE, 1);
      send_division(MOST_POS, 1);
      send_division(MOST_NEG, 1);
      send_division(MOST_NEG, MINUS_ONE);
      send_division(MOST_NEG, MOST_NEG);
      send_division(5, MOST_NEG);
      send_division(-5, MOST_NEG);
      send_division(MOST_POS, MOST_NEG);
      send_division('0, '0);
      send_division(MOST_NEG, '0);
      send_division(MOST_POS, '0);
      send_division(7, 2);
      send_division(-7, 2);
      send_division(7, -2);
      send_division(-7, -2);
      send_division(MOST_POS, MINUS_ONE);
      send_division(MOST_NEG, 2);
      send_division(MOST_POS, MOST_POS);
      send_division(1, MOST_POS);
      send_division(MINUS_ONE, MINUS_ONE);
      send_division(MOST_NEG, MOST_POS);
      send_division(100, 7);
      wait_for_results();
   endtask

   task automatic run_random(int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (RANDOM_PER_PHASE)
         send_division(pick_operand(), pick_operand());
      wait_for_results();
   endtask

   task automatic test_random_no_idle();
      run_random(0, 0);
   endtask

   task automatic test_random_sender_idle();
      run_random(59, 0);
   endtask

   task automatic test_random_receiver_stall();
      run_random(0, 59);
   endtask

   task automatic test_random_both_idle();
      run_random(16, 16);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_random_no_idle();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();
      receiver_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d divisions sent, %0d quotients checked, %0d of them by zero",
               divisions_sent, quotients_checked, zero_divisors);
      $display("corner operands plus random operands with and without idle and stall");
      if (failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/sid_pkg.sv
rtl/sid_cell.sv
rtl/signed_integer_divider_top.sv
tb/tb.sv
